// ===== design/itp_pkg.sv =====
// Package for the infix-to-postfix converter.
// Holds character codes, precedence helpers, the stack op and FSM types.
// No dependencies.
package itp_pkg;

    // Default operator stack depth
    localparam int unsigned STACK_DEPTH_DEF = 16;

    // Character codes
    localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
    localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
    localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
    localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
    localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'

    // Operation applied to every cell of the stack chain together
    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_POP
    } t_stk_op;

    // Control FSM states
    typedef enum logic [1:0] {
        S_IDLE,
        S_PROC,
        S_FLUSH
    } t_state;

    // Operator precedence: '*' '/' -> 2, '+' '-' -> 1, everything else -> 0
    function automatic logic [1:0] f_prec(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_STAR || c == CH_SLASH) begin
            p = 2'd2;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
            p = 2'd1;
        end
        return p;
    endfunction

    // Letters and digits go straight to the output
    function automatic logic f_is_operand(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

// ===== design/infix_to_postfix_converter_top.sv =====
// Top level of the infix-to-postfix (shunting-yard) converter.
// Control FSM, stack count, overflow flag and output register.
// Depends on itp_pkg and itp_stack.
//
//  Channel  | Handshake          | Words
//  ---------+--------------------+--------------------------------------------
//  input    | i_valid / o_ready  | i_symbol, i_end_of_expr
//  output   | o_valid / i_ready  | o_out_symbol, o_symbol_valid, o_expr_end,
//           |                    | o_overflow, o_last
//
// One character at a time: the character is accepted, then an operand is
// emitted, '(' is pushed, an operator pops each entry of equal or higher
// precedence and is then pushed, and ')' pops entries down to and including
// '('; an end-of-expression flush pops every remaining entry and then emits
// the end marker. Each pop shifts the whole stack chain.
// Synchronous active-low reset empties the stack and clears the overflow flag.
// A stalled output holds the FSM in place; nothing is dropped.
module infix_to_postfix_converter_top #(
    parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_symbol,
    input  logic       i_end_of_expr,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_symbol,
    output logic       o_symbol_valid,
    output logic       o_expr_end,
    output logic       o_overflow,
    output logic       o_last
);
    import itp_pkg::*;

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE  = CW'(1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_sym;
    logic          r_end;

    logic          r_o_valid;
    logic [7:0]    r_o_sym;
    logic          r_o_symv;
    logic          r_o_end;
    logic          r_o_ovf;
    logic          r_o_last;

    t_stk_op       w_op;
    logic [7:0]    w_top;
    logic [7:0]    w_next;
    logic          w_can_emit;
    logic          w_emit;
    logic [7:0]    w_e_sym;
    logic          w_e_symv;
    logic          w_e_end;
    logic          w_e_last;
    logic          w_in_acc;

    itp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk       (i_clk),
        .i_op        (w_op),
        .i_push_data (r_sym),
        .o_top       (w_top),
        .o_next      (w_next)
    );

    assign w_in_acc   = i_valid && o_ready;
    assign w_can_emit = !r_o_valid || i_ready;
    assign o_ready    = (r_state == S_IDLE);

    // State, count and flag registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // Input word capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sym <= i_symbol;
            r_end <= i_end_of_expr;
        end
    end

    // Next state, stack op and emitted word
    always_comb begin
        t_state after;
        after    = r_end ? S_FLUSH : S_IDLE;
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        w_op     = STK_HOLD;
        w_emit   = 1'b0;
        w_e_sym  = w_top;
        w_e_symv = 1'b1;
        w_e_end  = 1'b0;
        w_e_last = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                priority if (f_is_operand(r_sym)) begin
                    w_e_sym  = r_sym;
                    w_e_last = !r_end;
                    if (w_can_emit) begin
                        w_emit  = 1'b1;
                        n_state = after;
                    end
                end else if (r_sym == CH_RPAREN) begin
                    if (r_count == '0) begin
                        n_state = after;
                    end else if (w_top == CH_LPAREN) begin
                        w_op    = STK_POP;
                        n_count = r_count - ONE;
                        n_state = after;
                    end else if (w_can_emit) begin
                        w_emit   = 1'b1;
                        w_e_last = !r_end && (r_count == ONE || w_next == CH_LPAREN);
                        w_op     = STK_POP;
                        n_count  = r_count - ONE;
                        if (r_count == ONE) begin
                            n_state = after;
                        end
                    end
                end else if (r_sym != CH_LPAREN && r_count != '0 &&
                             f_prec(w_top) >= f_prec(r_sym)) begin
                    // Operator pops an entry of equal or higher precedence
                    if (w_can_emit) begin
                        w_emit   = 1'b1;
                        w_e_last = !r_end &&
                                   !(r_count > ONE && f_prec(w_next) >= f_prec(r_sym));
                        w_op     = STK_POP;
                        n_count  = r_count - ONE;
                    end
                end else begin
                    // Push '(' or operator; dropped on a full stack
                    if (r_count == FULL) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_op    = STK_PUSH;
                        n_count = r_count + ONE;
                    end
                    n_state = after;
                end
            end
            S_FLUSH: begin
                if (r_count != '0) begin
                    if (w_top == CH_LPAREN) begin
                        w_op    = STK_POP;
                        n_count = r_count - ONE;
                    end else if (w_can_emit) begin
                        w_emit  = 1'b1;
                        w_op    = STK_POP;
                        n_count = r_count - ONE;
                    end
                end else begin
                    // End marker carries the flag, then clears it
                    w_e_sym  = 8'h00;
                    w_e_symv = 1'b0;
                    w_e_end  = 1'b1;
                    w_e_last = 1'b1;
                    if (w_can_emit) begin
                        w_emit  = 1'b1;
                        n_ovf   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    // Output register word
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_sym  <= w_e_sym;
            r_o_symv <= w_e_symv;
            r_o_end  <= w_e_end;
            r_o_ovf  <= r_ovf;
            r_o_last <= w_e_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_symbol   = r_o_sym;
    assign o_symbol_valid = r_o_symv;
    assign o_expr_end     = r_o_end;
    assign o_overflow     = r_o_ovf;
    assign o_last         = r_o_last;

    // Stack count never passes the depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL)
        else $error("stack count above depth");

    // Overflow only rises on a push against a full stack
    a_ovf_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(r_count) == FULL)
        else $error("overflow set without full stack");

    // End marker is the final word of its item and carries no character
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_expr_end |-> o_last && !o_symbol_valid)
        else $error("bad end marker word");

    // The stack is empty once the end marker has been produced
    a_marker_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && w_e_end |=> r_count == '0 && !r_ovf)
        else $error("state not cleared after end marker");

endmodule

// ===== design/itp_cell.sv =====
// One entry of the operator stack chain.
// Takes its neighbor's byte on push (from above) or pop (from below).
// Depends on itp_pkg.
module itp_cell (
    input  logic            i_clk,
    input  itp_pkg::t_stk_op i_op,
    input  logic [7:0]      i_from_above,
    input  logic [7:0]      i_from_below,
    output logic [7:0]      o_entry
);
    import itp_pkg::*;

    logic [7:0] r_entry;

    // Shift with the rest of the chain
    always_ff @(posedge i_clk) begin
        unique case (i_op)
            STK_PUSH: r_entry <= i_from_above;
            STK_POP:  r_entry <= i_from_below;
            default:  r_entry <= r_entry;
        endcase
    end

    assign o_entry = r_entry;

endmodule

// ===== design/itp_stack.sv =====
// Operator stack as a row of shifting cells; cell 0 is always the top.
// Shows the top and the entry under it. Depends on itp_pkg, itp_cell.
module itp_stack #(
    parameter int unsigned STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic             i_clk,
    input  itp_pkg::t_stk_op i_op,
    input  logic [7:0]       i_push_data,
    output logic [7:0]       o_top,
    output logic [7:0]       o_next
);
    import itp_pkg::*;

    logic [7:0] w_entry [STACK_DEPTH];

    // Chain of cells, each wired to its two neighbors
    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [7:0] w_above;
        logic [7:0] w_below;

        if (g == 0) begin : g_first
            assign w_above = i_push_data;
        end else begin : g_mid_a
            assign w_above = w_entry[g-1];
        end

        if (g == STACK_DEPTH - 1) begin : g_last
            assign w_below = 8'h00;
        end else begin : g_mid_b
            assign w_below = w_entry[g+1];
        end

        itp_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (i_op),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .o_entry      (w_entry[g])
        );
    end

    assign o_top  = w_entry[0];
    assign o_next = w_entry[1];

endmodule

// ===== test/infix_to_postfix_converter_top_tb.sv =====
// Testbench for infix_to_postfix_converter_top: feeds infix characters and
// checks every postfix word against a shunting-yard scoreboard.
// Depends on itp_pkg and the converter RTL.
module infix_to_postfix_converter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import itp_pkg::*;

    localparam int unsigned STACK_DEPTH  = STACK_DEPTH_DEF;
    localparam int unsigned RANDOM_WORDS = 170;
    localparam int unsigned IDLE_PCT     = 17;
    localparam int unsigned HOLD_AFTER   = 30;   // results seen before the long stall
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned TIMEOUT_NS   = 2_000_000;

    // Operand range bounds and odd bytes
    localparam logic [7:0] CH_ZERO = "0";
    localparam logic [7:0] CH_NINE = "9";
    localparam logic [7:0] CH_UP_A = "A";
    localparam logic [7:0] CH_UP_Z = "Z";
    localparam logic [7:0] CH_LO_A = "a";
    localparam logic [7:0] CH_LO_Z = "z";
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_HIGH = 8'hFF;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic       symbol_valid;
        logic       expr_end;
        logic       overflow;
        logic       last;
    } t_postfix_word;

    // Shunting-yard predictor plus the queue of postfix words still owed
    class postfix_scoreboard;
        logic [7:0]    op_stack [STACK_DEPTH];
        int unsigned   op_count;
        bit            ovf_seen;
        t_postfix_word owed_q[$];
        t_postfix_word step_q[$];
        int unsigned   errors;

        function new();
            op_count = 0;
            ovf_seen = 1'b0;
            errors   = 0;
        endfunction

        static function int unsigned prio_of(logic [7:0] c);
            if (c == CH_STAR || c == CH_SLASH) return 2;
            if (c == CH_PLUS || c == CH_MINUS) return 1;
            return 0;
        endfunction

        static function bit is_operand(logic [7:0] c);
            return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z) ||
                   (c >= CH_ZERO && c <= CH_NINE);
        endfunction

        function void emit(logic [7:0] sym, bit valid, bit is_end);
            t_postfix_word w;
            w.out_symbol   = valid ? sym : 8'h00;
            w.symbol_valid = valid;
            w.expr_end     = is_end;
            w.overflow     = ovf_seen;
            w.last         = 1'b0;
            step_q.push_back(w);
        endfunction

        // push onto a full stack is dropped and flagged
        function void push(logic [7:0] c);
            if (op_count >= STACK_DEPTH) begin
                ovf_seen = 1'b1;
            end else begin
                op_stack[op_count] = c;
                op_count++;
            end
        endfunction

        function logic [7:0] pop();
            op_count--;
            return op_stack[op_count];
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction

        // Work out every word caused by one accepted character
        function void note_input(logic [7:0] sym, logic eoe);
            logic [7:0]    t;
            int unsigned   p;
            bit            done;
            t_postfix_word w;
            step_q.delete();
            if (is_operand(sym)) begin
                emit(sym, 1'b1, 1'b0);
            end else if (sym == CH_LPAREN) begin
                push(sym);
            end else if (sym == CH_RPAREN) begin
                done = 1'b0;
                while (op_count > 0 && !done) begin
                    t = pop();
                    if (t == CH_LPAREN) done = 1'b1;
                    else emit(t, 1'b1, 1'b0);
                end
            end else begin
                p = prio_of(sym);
                while (op_count > 0 && prio_of(op_stack[op_count - 1]) >= p) begin
                    t = pop();
                    emit(t, 1'b1, 1'b0);
                end
                push(sym);
            end
            // end of expression: flush, drop open parens, then the marker
            if (eoe) begin
                while (op_count > 0) begin
                    t = pop();
                    if (t != CH_LPAREN) emit(t, 1'b1, 1'b0);
                end
                emit(8'h00, 1'b0, 1'b1);
                ovf_seen = 1'b0;
            end
            if (step_q.size() > 0) begin
                w = step_q.pop_back();
                w.last = 1'b1;
                step_q.push_back(w);
            end
            foreach (step_q[i]) owed_q.push_back(step_q[i]);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_postfix_word got);
            t_postfix_word want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("out_symbol", want.out_symbol, got.out_symbol);
            compare_field("symbol_valid", 8'(want.symbol_valid), 8'(got.symbol_valid));
            compare_field("expr_end", 8'(want.expr_end), 8'(got.expr_end));
            compare_field("overflow", 8'(want.overflow), 8'(got.overflow));
            compare_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_symbol;
    logic       i_end_of_expr;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_symbol;
    logic       o_symbol_valid;
    logic       o_expr_end;
    logic       o_overflow;
    logic       o_last;

    postfix_scoreboard sb;
    int unsigned       words_sent;
    int unsigned       results_seen;

    infix_to_postfix_converter_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_symbol      (i_symbol),
        .i_end_of_expr (i_end_of_expr),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_symbol  (o_out_symbol),
        .o_symbol_valid(o_symbol_valid),
        .o_expr_end    (o_expr_end),
        .o_overflow    (o_overflow),
        .o_last        (o_last)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] random_operand();
        case ($urandom_range(2))
            0: return 8'(CH_ZERO + $urandom_range(9));
            1: return 8'(CH_UP_A + $urandom_range(25));
            default: return 8'(CH_LO_A + $urandom_range(25));
        endcase
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(3))
            0: return CH_PLUS;
            1: return CH_MINUS;
            2: return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Offer one word, with random idle cycles outside the steady window
    task automatic send_word(input logic [7:0] sym, input logic eoe);
        @(negedge i_clk);
        while (!(words_sent >= 110 && words_sent < 160) &&
               $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_symbol      <= sym;
        i_end_of_expr <= eoe;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(sym, eoe);
        words_sent++;
    endtask

    task automatic run_directed();
        // operand range edges
        send_word(CH_ZERO, 1'b0);
        send_word(CH_NINE, 1'b0);
        send_word(CH_UP_A, 1'b0);
        send_word(CH_UP_Z, 1'b0);
        send_word(CH_LO_A, 1'b0);
        send_word(CH_LO_Z, 1'b0);
        // close with nothing on the stack
        send_word(CH_RPAREN, 1'b0);
        // every operator inside a group, popped by precedence and by ')'
        send_word(CH_LPAREN, 1'b0);
        send_word(CH_PLUS, 1'b0);
        send_word(CH_LO_A, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_word(CH_UP_Z, 1'b0);
        send_word(CH_MINUS, 1'b0);
        send_word(CH_NINE, 1'b0);
        send_word(CH_SLASH, 1'b0);
        send_word(CH_UP_A, 1'b0);
        send_word(CH_RPAREN, 1'b0);
        // unknown bytes pop everything, open parens too
        send_word(CH_LPAREN, 1'b0);
        send_word(CH_STAR, 1'b0);
        send_word(CH_HIGH, 1'b0);
        send_word(CH_NUL, 1'b0);
        send_word(CH_LO_Z, 1'b1);
        // end on an empty stack, and an open paren flushed away at the end
        send_word(CH_RPAREN, 1'b1);
        send_word(CH_LPAREN, 1'b1);
    endtask

    // Well-formed expression with random content; broken ones get one bad char and may lose closing parens
    task automatic run_expression(input bit broken);
        logic [7:0]  chars[$];
        int unsigned depth;
        int unsigned max_depth;
        int unsigned terms;
        int unsigned pos;
        bit          want_operand;
        max_depth    = ($urandom_range(7) == 0) ? STACK_DEPTH / 2 : $urandom_range(3);
        terms        = $urandom_range(1, 8);
        depth        = 0;
        want_operand = 1'b1;
        while (terms > 0) begin
            if (want_operand) begin
                if (depth < max_depth && $urandom_range(2) == 0) begin
                    chars.push_back(CH_LPAREN);
                    depth++;
                end else begin
                    chars.push_back(random_operand());
                    want_operand = 1'b0;
                    terms--;
                end
            end else if (depth > 0 && $urandom_range(2) == 0) begin
                chars.push_back(CH_RPAREN);
                depth--;
            end else begin
                chars.push_back(random_operator());
                want_operand = 1'b1;
            end
        end
        if (!(broken && $urandom_range(1) == 0)) begin
            repeat (depth) chars.push_back(CH_RPAREN);
        end
        if (broken) begin
            pos = $urandom_range(chars.size() - 1);
            case ($urandom_range(3))
                0: chars[pos] = random_operator();
                1: chars[pos] = CH_LPAREN;
                2: chars[pos] = CH_RPAREN;
                default: chars[pos] = 8'($urandom_range(255));
            endcase
        end
        foreach (chars[i]) send_word(chars[i], i == chars.size() - 1);
    endtask

    // Nest past the stack depth so pushes can get dropped
    task automatic run_overflow_burst();
        int unsigned n;
        n = STACK_DEPTH + $urandom_range(1, 3);
        repeat (n) send_word(($urandom_range(3) == 0) ? random_operator() : CH_LPAREN, 1'b0);
        send_word(random_operand(), 1'b0);
        if ($urandom_range(1) == 0) begin
            repeat ($urandom_range(1, 4)) send_word(CH_RPAREN, 1'b0);
        end
        send_word(random_operand(), 1'b1);
    endtask

    task automatic run_random();
        int unsigned start;
        int unsigned pick;
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                run_expression(1'b0);
            end else if (pick < 75) begin
                run_overflow_burst();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) begin
                    send_word(8'($urandom_range(255)), $urandom_range(3) == 0);
                end
            end else begin
                run_expression(1'b1);
            end
        end
    endtask

    // Receiver: random stalls, one long hold-off, and a steady window
    initial begin
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_ready   = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else if (results_seen >= 120 && results_seen < 220) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Check each accepted word
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            sb.check_result({o_out_symbol, o_symbol_valid, o_expr_end, o_overflow, o_last});
            results_seen++;
        end
    end

    // Main sequence
    initial begin
        sb            = new();
        words_sent    = 0;
        results_seen  = 0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_symbol      = 8'h00;
        i_end_of_expr = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        run_random();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
